/* rtl/sfd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the stereo feedback delay.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam int SAMPLE_W    = 24;
  localparam int ADDR_W      = 17;
  localparam int DEPTH       = 1 << ADDR_W;
  localparam int DLEN_W      = 17;
  localparam int GAIN_W      = 16;
  localparam int PROD_W      = SAMPLE_W + GAIN_W + 1;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int PING_OFFSET = 20;
  localparam int FIFO_DEPTH  = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0]          addr_t;
  typedef logic signed [PROD_W-1:0]   prod_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } pair_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE   = 3'd0,
    REG_DLEN     = 3'd1,
    REG_FEEDBACK = 3'd2,
    REG_MIX      = 3'd3,
    REG_PING     = 3'd4
  } cfg_reg_t;

endpackage
`default_nettype wire

/* rtl/sfd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_in_if / sfd_out_if
// Valid/ready stream channels carrying one stereo sample pair per transfer.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic             valid;
  logic             ready;
  sfd_pkg::sample_t left_in;
  sfd_pkg::sample_t right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sfd_out_if;
  logic             valid;
  logic             ready;
  sfd_pkg::sample_t left_out;
  sfd_pkg::sample_t right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

/* rtl/sfd_delay_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_delay_ram
// One delay line store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sfd_delay_ram (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire sfd_pkg::addr_t   waddr,
  input  wire sfd_pkg::sample_t wdata,
  input  wire logic             re,
  input  wire sfd_pkg::addr_t   raddr,
  output sfd_pkg::sample_t      rdata
);

  sfd_pkg::sample_t mem_r [sfd_pkg::DEPTH];
  sfd_pkg::sample_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/sfd_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfd_out_fifo
// Two-entry result queue; decouples the pipeline from receiver stalls.
// ----------------------------------------------------------------------------
module sfd_out_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire sfd_pkg::pair_t push_data,
  output logic [1:0]          count,
  sfd_out_if.source           out_ch
);

  sfd_pkg::pair_t entry_r [sfd_pkg::FIFO_DEPTH];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           pop;

  assign pop = out_ch.valid & out_ch.ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign count            = cnt_r;
  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.left_out  = entry_r[rd_ptr_r].left;
  assign out_ch.right_out = entry_r[rd_ptr_r].right;

endmodule
`default_nettype wire

/* rtl/stereo_feedback_delay.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_feedback_delay
// Stereo feedback echo with optional ping offset on the right line.
//
// Usage:
// - in_ch takes one stereo Q1.23 pair per transfer; out_ch returns exactly
//   one processed pair per input transfer, in order.
// - cfg_we/cfg_index/cfg_wdata write the settings (enable, delay_length,
//   feedback_gain, mix_gain, ping_mode). Write only while the block is idle.
// - Input spacing: in_ch.ready stays low while a pair is in stage 1. The
//   limit is the read-modify-write loop through each delay memory: a pair's
//   write-back can land in the same cycle the next pair reads, and is then
//   forwarded to it. Each pair is read, multiplied, then rounded/added/
//   saturated and written back as it is pushed into the output queue.
// - Reset: settings go to their defaults, write position to zero. The
//   memories are not swept; entries not yet written since reset read as
//   zero, tracked by the write position and a wrapped flag. No busy time;
//   in_ch.ready is held low while rst_n is low.
// - Receiver stall: a two-entry output queue absorbs finished pairs;
//   in_ch.ready drops once the queue plus the pair in flight would fill it.
// - Disabled: pairs pass through unchanged; memories and position hold.
// ----------------------------------------------------------------------------
module stereo_feedback_delay (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  sfd_in_if.sink                                in_ch,
  sfd_out_if.source                             out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [sfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [sfd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int SW = sfd_pkg::SAMPLE_W;
  localparam int PW = sfd_pkg::PROD_W;
  localparam int AW = sfd_pkg::ADDR_W;
  localparam int GW = sfd_pkg::GAIN_W;
  localparam int DW = sfd_pkg::DLEN_W;
  localparam sfd_pkg::prod_t ROUND_BIAS = PW'(1) << (GW - 1);
  localparam sfd_pkg::addr_t LAST_ADDR  = AW'(sfd_pkg::DEPTH - 1);

  // round(x + p / 2^16) with ties up, saturated to sample width
  function automatic sfd_pkg::sample_t mac_sat(sfd_pkg::sample_t x, sfd_pkg::prod_t p);
    sfd_pkg::prod_t      pr;
    logic signed [SW+1:0] sum;
    pr  = p + ROUND_BIAS;
    sum = $signed({{2{x[SW-1]}}, x}) + $signed({pr[PW-1], pr[PW-1:GW]});
    if (sum[SW+1:SW-1] == 3'b000 || sum[SW+1:SW-1] == 3'b111) begin
      mac_sat = sum[SW-1:0];
    end else if (sum[SW+1]) begin
      mac_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      mac_sat = {1'b0, {(SW-1){1'b1}}};
    end
  endfunction

  // ---------------- configuration ----------------
  logic          enable_r;
  logic [DW-1:0] dlen_r;
  logic [GW-1:0] fb_r;
  logic [GW-1:0] mix_r;
  logic          ping_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      dlen_r   <= DW'(1);
      fb_r     <= '0;
      mix_r    <= '0;
      ping_r   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        sfd_pkg::REG_ENABLE:   enable_r <= cfg_wdata[0];
        sfd_pkg::REG_DLEN:     dlen_r   <= cfg_wdata[DW-1:0];
        sfd_pkg::REG_FEEDBACK: fb_r     <= cfg_wdata[GW-1:0];
        sfd_pkg::REG_MIX:      mix_r    <= cfg_wdata[GW-1:0];
        sfd_pkg::REG_PING:     ping_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // ---------------- pipeline state ----------------
  logic             in_xfer;
  logic [1:0]       fifo_cnt;

  sfd_pkg::addr_t   wp_r;          // next write position
  logic             wrapped_r;     // every entry written at least once

  // stage 1: memory data arrives
  logic             s1_valid_r;
  logic             s1_en_r, s1_ping_r;
  sfd_pkg::sample_t s1_inl_r, s1_inr_r;
  sfd_pkg::addr_t   s1_wa_r;
  logic             s1_ok_l_r, s1_ok_r_r;
  logic             s1_fwd_l_r, s1_fwd_r_r;
  sfd_pkg::sample_t s1_fwd_ld_r, s1_fwd_rd_r;

  // stage 2: products registered, round/add/saturate, write-back
  logic             s2_valid_r;
  logic             s2_en_r, s2_ping_r;
  sfd_pkg::sample_t s2_inl_r, s2_inr_r;
  sfd_pkg::addr_t   s2_wa_r;
  sfd_pkg::prod_t   s2_pfl_r, s2_pml_r, s2_pfr_r, s2_pmr_r;

  // credit check: the queue must have room for this pair and the one in stage 2
  assign in_ch.ready = rst_n && !s1_valid_r &&
                       ({1'b0, fifo_cnt} + {2'b00, s2_valid_r} < 3'(sfd_pkg::FIFO_DEPTH));
  assign in_xfer = in_ch.valid & in_ch.ready;

  // ---------------- read address, fill check, forwarding ----------------
  logic [DW:0]      roff_sum;
  sfd_pkg::addr_t   ra_l, ra_r;
  logic             ok_l, ok_r;
  logic             wr_en;
  sfd_pkg::sample_t st_l, st_r, res_l, res_r;

  always_comb begin
    roff_sum = {1'b0, dlen_r} + (ping_r ? (DW+1)'(sfd_pkg::PING_OFFSET) : '0);
    ra_l     = wp_r - dlen_r[AW-1:0];
    ra_r     = wp_r - roff_sum[AW-1:0];
    // entries below the write position were written since reset
    ok_l     = wrapped_r || (ra_l < wp_r);
    ok_r     = wrapped_r || (ra_r < wp_r);
  end

  assign wr_en = s2_valid_r & s2_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      wrapped_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_xfer;
      s2_valid_r <= s1_valid_r;
      if (in_xfer && enable_r) begin
        wp_r <= wp_r + AW'(1);
        if (wp_r == LAST_ADDR) begin
          wrapped_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_en_r     <= enable_r;
      s1_ping_r   <= ping_r;
      s1_inl_r    <= in_ch.left_in;
      s1_inr_r    <= in_ch.right_in;
      s1_wa_r     <= wp_r;
      s1_ok_l_r   <= ok_l;
      s1_ok_r_r   <= ok_r;
      // same-cycle write-back from the pair ahead wins over stale memory data
      s1_fwd_l_r  <= wr_en && (s2_wa_r == ra_l);
      s1_fwd_r_r  <= wr_en && (s2_wa_r == ra_r);
      s1_fwd_ld_r <= st_l;
      s1_fwd_rd_r <= st_r;
    end
  end

  // ---------------- memories ----------------
  sfd_pkg::sample_t ram_l_q, ram_r_q;

  sfd_delay_ram u_ram_l (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_wa_r),
    .wdata (st_l),
    .re    (in_xfer),
    .raddr (ra_l),
    .rdata (ram_l_q)
  );

  sfd_delay_ram u_ram_r (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s2_wa_r),
    .wdata (st_r),
    .re    (in_xfer),
    .raddr (ra_r),
    .rdata (ram_r_q)
  );

  // ---------------- stage 1: echo select and gain multiply ----------------
  sfd_pkg::sample_t echo_l, echo_r;

  always_comb begin
    if (s1_fwd_l_r) begin
      echo_l = s1_fwd_ld_r;
    end else if (s1_ok_l_r) begin
      echo_l = ram_l_q;
    end else begin
      echo_l = '0;
    end
    if (s1_fwd_r_r) begin
      echo_r = s1_fwd_rd_r;
    end else if (s1_ok_r_r) begin
      echo_r = ram_r_q;
    end else begin
      echo_r = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      s2_en_r   <= s1_en_r;
      s2_ping_r <= s1_ping_r;
      s2_inl_r  <= s1_inl_r;
      s2_inr_r  <= s1_inr_r;
      s2_wa_r   <= s1_wa_r;
      s2_pfl_r  <= echo_l * $signed({1'b0, fb_r});
      s2_pml_r  <= echo_l * $signed({1'b0, mix_r});
      s2_pfr_r  <= echo_r * $signed({1'b0, fb_r});
      s2_pmr_r  <= echo_r * $signed({1'b0, mix_r});
    end
  end

  // ---------------- stage 2: round, add, saturate ----------------
  sfd_pkg::pair_t push_data;

  always_comb begin
    st_l  = mac_sat(s2_inl_r, s2_pfl_r);
    st_r  = mac_sat(s2_ping_r ? s2_inr_r : s2_inl_r, s2_pfr_r);
    res_l = mac_sat(s2_inl_r, s2_pml_r);
    res_r = mac_sat(s2_inr_r, s2_pmr_r);
    if (s2_en_r) begin
      push_data.left  = res_l;
      push_data.right = res_r;
    end else begin
      push_data.left  = s2_inl_r;
      push_data.right = s2_inr_r;
    end
  end

  sfd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s2_valid_r),
    .push_data (push_data),
    .count     (fifo_cnt),
    .out_ch    (out_ch)
  );

  // ---------------- assertions ----------------
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_xfer)
    else $error("input transfers closer than two cycles");

  a_fifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (fifo_cnt < 2'(sfd_pkg::FIFO_DEPTH)))
    else $error("result pushed into full queue");

  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_en_r) |-> (push_data.left == s2_inl_r && push_data.right == s2_inr_r))
    else $error("disabled pair not passed through");

  a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_xfer && enable_r)) |=> $stable(wp_r))
    else $error("write position moved without an enabled transfer");

  a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    wrapped_r |=> wrapped_r)
    else $error("wrapped flag cleared outside reset");

endmodule
`default_nettype wire
